// File: sv/skf_pkg.sv
`default_nettype none

package skf_pkg;

  localparam int SAMPLE_WIDTH = 16;
  localparam int FRAC_BITS    = 20;

  localparam int EST_WIDTH  = 32;
  localparam int EST_FRAC   = 16;
  localparam int REG_WIDTH  = 24;
  localparam int GAIN_WIDTH = FRAC_BITS + 1;
  localparam int VAR_WIDTH  = FRAC_BITS + 6;
  localparam int DEN_WIDTH  = ((VAR_WIDTH > REG_WIDTH) ? VAR_WIDTH : REG_WIDTH) + 1;

  localparam int ONE_INT       = 1 << FRAC_BITS;
  localparam int Q_DEFAULT_INT = (ONE_INT + 50) / 100;
  localparam int R_DEFAULT_INT = (ONE_INT + 5) / 10;

  localparam logic [REG_WIDTH-1:0] Q_DEFAULT = REG_WIDTH'(Q_DEFAULT_INT);
  localparam logic [REG_WIDTH-1:0] R_DEFAULT = REG_WIDTH'(R_DEFAULT_INT);

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  localparam logic [0:0] REG_PROCESS_NOISE     = 1'b0;
  localparam logic [0:0] REG_MEASUREMENT_NOISE = 1'b1;

  typedef struct packed {
    logic signed [EST_WIDTH-1:0] z;
    logic                        restart;
  } item_t;

  typedef struct packed {
    logic                 en;
    logic [0:0]           index;
    logic [REG_WIDTH-1:0] data;
  } cfg_write_t;

endpackage

`default_nettype wire

// File: sv/skf_front.sv
`default_nettype none

module skf_front (
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [skf_pkg::SAMPLE_WIDTH-1:0] sample,
  input  wire logic                                    restart,
  input  wire logic                                    queue_full,
  output logic                                         push,
  output skf_pkg::item_t                               push_item
);

  localparam int SW  = skf_pkg::SAMPLE_WIDTH;
  localparam int SXW = SW + 17;
  localparam int EW  = skf_pkg::EST_WIDTH;
  localparam int EF  = skf_pkg::EST_FRAC;

  localparam logic signed [SXW-1:0] S_HI = {{(SXW-EW+EF+1){1'b0}}, {(EW-EF-1){1'b1}}};
  localparam logic signed [SXW-1:0] S_LO = {{(SXW-EW+EF+1){1'b1}}, {(EW-EF-1){1'b0}}};
  localparam logic signed [EW-1:0]  Z_MAX = {1'b0, {(EW-1){1'b1}}};
  localparam logic signed [EW-1:0]  Z_MIN = {1'b1, {(EW-1){1'b0}}};

  logic signed [SXW-1:0] s_ext;
  logic signed [EW-1:0]  z;

  assign s_ext = {{17{sample[SW-1]}}, sample};

  // scale to Q16.16 with clamp to the 32-bit range
  always_comb begin
    if (s_ext > S_HI) begin
      z = Z_MAX;
    end else if (s_ext < S_LO) begin
      z = Z_MIN;
    end else begin
      z = {s_ext[EW-EF-1:0], {EF{1'b0}}};
    end
  end

  assign in_stall          = queue_full;
  assign push              = in_valid && !queue_full;
  assign push_item.z       = z;
  assign push_item.restart = restart;

endmodule

`default_nettype wire

// File: sv/skf_queue.sv
`default_nettype none

module skf_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire skf_pkg::item_t push_item,
  output logic                full,
  input  wire logic           pop,
  output skf_pkg::item_t      pop_item,
  output logic                valid
);

  localparam int D  = skf_pkg::QUEUE_DEPTH;
  localparam int AW = skf_pkg::QUEUE_AW;

  skf_pkg::item_t entries [D];
  logic [AW-1:0]  wr_ptr;
  logic [AW-1:0]  rd_ptr;
  logic [AW:0]    count;
  logic           do_push;
  logic           do_pop;

  assign full     = (count == (AW+1)'(D));
  assign valid    = (count != '0);
  assign pop_item = entries[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == AW'(D-1)) ? '0 : wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == AW'(D-1)) ? '0 : rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (AW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (AW+1)'(1);
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= (AW+1)'(D))
    else $error("queue count beyond depth");

  a_empty_ptrs: assert property (@(posedge clk) disable iff (rst)
    !valid |-> (wr_ptr == rd_ptr))
    else $error("empty queue with unequal pointers");

endmodule

`default_nettype wire

// File: sv/skf_back.sv
`default_nettype none

module skf_back (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire skf_pkg::cfg_write_t                     cfg,
  input  wire logic                                    queue_valid,
  input  wire skf_pkg::item_t                          queue_item,
  output logic                                         pop,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [skf_pkg::EST_WIDTH-1:0]         estimate,
  output logic        [skf_pkg::GAIN_WIDTH-1:0]        gain
);

  localparam int F   = skf_pkg::FRAC_BITS;
  localparam int EW  = skf_pkg::EST_WIDTH;
  localparam int VW  = skf_pkg::VAR_WIDTH;
  localparam int DW  = skf_pkg::DEN_WIDTH;
  localparam int RW  = skf_pkg::REG_WIDTH;
  localparam int DFW = EW + 1;
  localparam int XW  = EW + 3;
  localparam int CW  = $clog2(F);

  localparam logic [VW-1:0]        VAR_MAX = '1;
  localparam logic [VW-1:0]        VAR_ONE = VW'(skf_pkg::ONE_INT);
  localparam logic [F:0]           K_ONE   = (F+1)'(skf_pkg::ONE_INT);
  localparam logic signed [XW-1:0] X_MAX   = {{(XW-EW+1){1'b0}}, {(EW-1){1'b1}}};
  localparam logic signed [XW-1:0] X_MIN   = {{(XW-EW+1){1'b1}}, {(EW-1){1'b0}}};

  typedef enum logic [5:0] {
    ST_IDLE = 6'b000001,
    ST_PRED = 6'b000010,
    ST_DIV  = 6'b000100,
    ST_MUL  = 6'b001000,
    ST_UPD  = 6'b010000,
    ST_DONE = 6'b100000
  } state_t;

  state_t                 state;
  logic [RW-1:0]          q_noise;
  logic [RW-1:0]          r_noise;
  logic signed [EW-1:0]   est;
  logic [VW-1:0]          err_var;
  logic                   seeded;
  logic signed [EW-1:0]   z;
  logic [VW-1:0]          p1;
  logic [DW-1:0]          den;
  logic [DW-1:0]          rem;
  logic [F-1:0]           quo;
  logic [CW-1:0]          cnt;
  logic [DFW+F-1:0]       prod_e;
  logic                   neg;
  logic [VW+F:0]          prod_v;

  logic [DW-1:0]          pred_sum;
  logic [VW-1:0]          p1_sat;
  logic [DW-1:0]          den_sum;
  logic [DW:0]            rem2;
  logic                   rem_ge;
  logic signed [DFW-1:0]  diff;
  logic [DFW-1:0]         mag;
  logic [F:0]             omk;
  logic [DFW+F:0]         dsum;
  logic [EW+1:0]          dmag;
  logic signed [XW-1:0]   xsum;
  logic signed [EW-1:0]   est_new;
  logic                   out_free;
  logic                   load_out;

  // predict with clamp, then divisor
  assign pred_sum = DW'(err_var) + DW'(q_noise);
  assign p1_sat   = (pred_sum > DW'(VAR_MAX)) ? VAR_MAX : pred_sum[VW-1:0];
  assign den_sum  = DW'(p1_sat) + DW'(r_noise);

  // restoring divider step
  assign rem2   = {rem, 1'b0};
  assign rem_ge = (rem2 >= {1'b0, den});

  assign diff = {z[EW-1], z} - {est[EW-1], est};
  assign mag  = diff[DFW-1] ? DFW'(-diff) : DFW'(diff);
  assign omk  = K_ONE - {1'b0, quo};

  // negative corrections round toward minus infinity
  assign dsum = {1'b0, prod_e} + (neg ? (DFW+F+1)'(K_ONE - (F+1)'(1)) : '0);
  assign dmag = dsum[F +: EW+2];
  assign xsum = {{(XW-EW){est[EW-1]}}, est}
              + (neg ? -$signed({1'b0, dmag}) : $signed({1'b0, dmag}));

  always_comb begin
    if (xsum > X_MAX) begin
      est_new = {1'b0, {(EW-1){1'b1}}};
    end else if (xsum < X_MIN) begin
      est_new = {1'b1, {(EW-1){1'b0}}};
    end else begin
      est_new = xsum[EW-1:0];
    end
  end

  assign pop      = (state == ST_IDLE) && queue_valid;
  assign out_free = !out_valid || !out_stall;
  assign load_out = (state == ST_DONE) && out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      q_noise   <= skf_pkg::Q_DEFAULT;
      r_noise   <= skf_pkg::R_DEFAULT;
      est       <= '0;
      err_var   <= VAR_ONE;
      seeded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cfg.en) begin
        unique case (cfg.index)
          skf_pkg::REG_PROCESS_NOISE: begin
            q_noise <= cfg.data;
          end
          skf_pkg::REG_MEASUREMENT_NOISE: begin
            r_noise <= (cfg.data == '0) ? skf_pkg::R_DEFAULT : cfg.data;
          end
          default: begin
          end
        endcase
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (queue_valid) begin
            z <= queue_item.z;
            if (queue_item.restart || !seeded) begin
              est     <= queue_item.z;
              err_var <= VAR_ONE;
              seeded  <= 1'b1;
            end
            state <= ST_PRED;
          end
        end
        ST_PRED: begin
          p1    <= p1_sat;
          den   <= den_sum;
          rem   <= DW'(p1_sat);
          quo   <= '0;
          cnt   <= '0;
          state <= ST_DIV;
        end
        ST_DIV: begin
          rem <= rem_ge ? DW'(rem2 - {1'b0, den}) : DW'(rem2);
          quo <= {quo[F-2:0], rem_ge};
          cnt <= cnt + CW'(1);
          if (cnt == CW'(F-1)) begin
            state <= ST_MUL;
          end
        end
        ST_MUL: begin
          prod_e <= {{F{1'b0}}, mag} * {{DFW{1'b0}}, quo};
          neg    <= diff[DFW-1];
          prod_v <= {{(F+1){1'b0}}, p1} * {{VW{1'b0}}, omk};
          state  <= ST_UPD;
        end
        ST_UPD: begin
          est     <= est_new;
          err_var <= prod_v[F +: VW];
          state   <= ST_DONE;
        end
        ST_DONE: begin
          if (out_free) begin
            estimate  <= est;
            gain      <= {1'b0, quo};
            state     <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  a_gain_below_one: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (gain < K_ONE))
    else $error("gain reached one");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIV) |-> (rem < den))
    else $error("divider remainder not below divisor");

  a_done_loads: assert property (@(posedge clk) disable iff (rst)
    ((state == ST_DONE) && out_free) |=> (out_valid && (state == ST_IDLE)))
    else $error("result not loaded on completion");

endmodule

`default_nettype wire

// File: sv/scalar_kalman_filter_core.sv
// Scalar random-walk Kalman filter. Each transfer on the input side carries one signed
// sensor sample (and a restart flag that reseeds the filter from that sample); each
// transfer on the output side carries the Q16.16 estimate after that sample and the
// Q1.20 gain used. Samples are scaled and clamped on entry and held in a two-entry queue,
// so the input keeps accepting while the filter works, until the queue is full. A sample
// passes through queue pop, predict, the restoring divider (one gain bit per cycle), a
// multiply step and an update step, then the output register load, which waits while
// the output stalls. q and r are to be written through the configuration port only while
// the block is idle; the block does not enforce it. A zero write of r stores 0.1 instead.
`default_nettype none

module scalar_kalman_filter_core (
  input  wire logic                                    clk,
  input  wire logic                                    rst,
  input  wire logic                                    cfg_write_en,
  input  wire logic [0:0]                              cfg_index,
  input  wire logic [skf_pkg::REG_WIDTH-1:0]           cfg_data,
  input  wire logic                                    in_valid,
  output logic                                         in_stall,
  input  wire logic signed [skf_pkg::SAMPLE_WIDTH-1:0] sample,
  input  wire logic                                    restart,
  output logic                                         out_valid,
  input  wire logic                                    out_stall,
  output logic signed [skf_pkg::EST_WIDTH-1:0]         estimate,
  output logic        [skf_pkg::GAIN_WIDTH-1:0]        gain
);

  skf_pkg::item_t     push_item;
  skf_pkg::item_t     pop_item;
  skf_pkg::cfg_write_t cfg;
  logic               push;
  logic               pop;
  logic               queue_full;
  logic               queue_valid;

  assign cfg.en    = cfg_write_en;
  assign cfg.index = cfg_index;
  assign cfg.data  = cfg_data;

  skf_front u_front (
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .sample     (sample),
    .restart    (restart),
    .queue_full (queue_full),
    .push       (push),
    .push_item  (push_item)
  );

  skf_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .full      (queue_full),
    .pop       (pop),
    .pop_item  (pop_item),
    .valid     (queue_valid)
  );

  skf_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .queue_valid (queue_valid),
    .queue_item  (pop_item),
    .pop         (pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .estimate    (estimate),
    .gain        (gain)
  );

endmodule

`default_nettype wire

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

  localparam longint unsigned ONE     = 64'd1 << skf_pkg::FRAC_BITS;
  localparam longint unsigned VAR_MAX = (64'd1 << skf_pkg::VAR_WIDTH) - 1;
  localparam logic [skf_pkg::REG_WIDTH-1:0] Q_RESET = skf_pkg::REG_WIDTH'((ONE + 50) / 100);
  localparam logic [skf_pkg::REG_WIDTH-1:0] R_RESET = skf_pkg::REG_WIDTH'((ONE + 5) / 10);
  localparam int DRAIN_CYCLES = skf_pkg::FRAC_BITS + 10;
  localparam int LONG_HOLD    = 300;
  localparam int TIMEOUT_NS   = 5_000_000;
  localparam int N_ROWS       = 31;
  localparam int N_PHASES     = 6;
  localparam int PHASE_ITEMS  = 100;

  typedef struct packed {
    logic signed [skf_pkg::EST_WIDTH-1:0] est;
    logic [skf_pkg::GAIN_WIDTH-1:0]       gain;
  } est_gain_t;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_SET_Q, ROW_SET_R} row_kind_t;

  typedef struct {
    row_kind_t                            kind;
    logic [skf_pkg::REG_WIDTH-1:0]        val;
    logic                                 rs;
    bit                                   chk_est;
    logic signed [skf_pkg::EST_WIDTH-1:0] est;
    bit                                   chk_gain;
    logic [skf_pkg::GAIN_WIDTH-1:0]       gain;
  } row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write_en = 1'b0;
  logic [0:0] cfg_index = '0;
  logic [skf_pkg::REG_WIDTH-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [skf_pkg::SAMPLE_WIDTH-1:0] sample = '0;
  logic restart = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [skf_pkg::EST_WIDTH-1:0] estimate;
  logic [skf_pkg::GAIN_WIDTH-1:0] gain;

  // filter state and noise settings as the block should hold them
  logic [skf_pkg::REG_WIDTH-1:0] q_noise = Q_RESET;
  logic [skf_pkg::REG_WIDTH-1:0] r_noise = R_RESET;
  longint x_est = 0;
  longint unsigned p_var = ONE;
  bit is_seeded = 1'b0;

  // expected estimate/gain per accepted input transfer, oldest first
  est_gain_t est_gain_q[$];
  int results_seen = 0;
  int mismatch_count = 0;

  row_t directed_rows [N_ROWS] = '{
    '{ROW_SAMPLE, 24'h000000, 1'b0, 1'b1, 32'h00000000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h007FFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h008000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h008000, 1'b1, 1'b1, 32'h80000000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h007FFF, 1'b1, 1'b1, 32'h7FFF0000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h000001, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h00FFFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h008000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_Q,  24'h000000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_R,  24'h100000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h000064, 1'b1, 1'b1, 32'h00640000, 1'b1, 21'h080000},
    '{ROW_SAMPLE, 24'h000064, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h00FF9C, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_R,  24'h000000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h00FFFB, 1'b1, 1'b1, 32'hFFFB0000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h000007, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_Q,  24'hFFFFFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_R,  24'h000001, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h0003E8, 1'b1, 1'b1, 32'h03E80000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h00FC18, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h007FFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_R,  24'hFFFFFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h008000, 1'b1, 1'b1, 32'h80000000, 1'b0, '0},
    '{ROW_SAMPLE, 24'h007FFF, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h008000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_Q,  24'h000000, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h001234, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h001234, 1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SAMPLE, 24'h000000, 1'b1, 1'b1, 32'h00000000, 1'b0, '0},
    '{ROW_SET_Q,  Q_RESET,    1'b0, 1'b0, '0, 1'b0, '0},
    '{ROW_SET_R,  R_RESET,    1'b0, 1'b0, '0, 1'b0, '0}
  };

  scalar_kalman_filter_core dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .sample       (sample),
    .restart      (restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .estimate     (estimate),
    .gain         (gain)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic longint clamp32(input longint v);
    if (v > longint'(32'sh7FFFFFFF)) return longint'(32'sh7FFFFFFF);
    if (v < longint'(32'sh80000000)) return longint'(32'sh80000000);
    return v;
  endfunction

  function automatic est_gain_t kalman_update(
      input logic signed [skf_pkg::SAMPLE_WIDTH-1:0] smp, input logic rs);
    longint z, diff, delta;
    longint unsigned p1, k, omk;
    est_gain_t res;
    z = clamp32(longint'(smp) * 65536);
    if (rs || !is_seeded) begin
      x_est = z;
      p_var = ONE;
      is_seeded = 1'b1;
    end
    p1 = p_var + q_noise;
    if (p1 > VAR_MAX) p1 = VAR_MAX;
    k = (p1 << skf_pkg::FRAC_BITS) / (p1 + r_noise);
    // floor of the signed product, towards minus infinity
    diff = z - x_est;
    delta = (diff * longint'(k)) >>> skf_pkg::FRAC_BITS;
    x_est = clamp32(x_est + delta);
    omk = ONE - k;
    p_var = (p1 >> skf_pkg::FRAC_BITS) * omk
          + (((p1 & (ONE - 1)) * omk) >> skf_pkg::FRAC_BITS);
    if (p_var > VAR_MAX) p_var = VAR_MAX;
    res.est = skf_pkg::EST_WIDTH'(x_est);
    res.gain = skf_pkg::GAIN_WIDTH'(k);
    return res;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report_mismatch(input string field, input longint got, input longint want);
    if (mismatch_count < 100)
      $display("mismatch at %0t: %s got %0d expected %0d", $time, field, got, want);
    mismatch_count++;
  endtask

  task automatic offer_sample(input logic signed [skf_pkg::SAMPLE_WIDTH-1:0] smp,
                              input logic rs, input bit chk_est,
                              input logic signed [skf_pkg::EST_WIDTH-1:0] est_typed,
                              input bit chk_gain,
                              input logic [skf_pkg::GAIN_WIDTH-1:0] gain_typed);
    est_gain_t exp_res;
    in_valid <= 1'b1;
    sample <= smp;
    restart <= rs;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    exp_res = kalman_update(smp, rs);
    if (chk_est) exp_res.est = est_typed;
    if (chk_gain) exp_res.gain = gain_typed;
    est_gain_q = {est_gain_q, exp_res};
    @(negedge clk);
  endtask

  task automatic idle_input(input int n);
    if (n > 0) begin
      in_valid <= 1'b0;
      repeat (n) begin
        sample <= skf_pkg::SAMPLE_WIDTH'($urandom);
        restart <= 1'($urandom);
        @(negedge clk);
      end
    end
  endtask

  task automatic quiesce();
    in_valid <= 1'b0;
    while (est_gain_q.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic write_noise_reg(input logic [0:0] idx,
                                 input logic [skf_pkg::REG_WIDTH-1:0] data);
    cfg_write_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(negedge clk);
    cfg_write_en <= 1'b0;
    @(negedge clk);
    if (idx == skf_pkg::REG_PROCESS_NOISE) q_noise = data;
    else if (idx == skf_pkg::REG_MEASUREMENT_NOISE) r_noise = (data == '0) ? R_RESET : data;
  endtask

  always @(posedge clk) begin
    est_gain_t exp_res;
    if (!rst && out_valid && !out_stall) begin
      results_seen++;
      if (est_gain_q.size() == 0) begin
        report_mismatch("unexpected result, estimate", estimate, 0);
      end else begin
        exp_res = est_gain_q.pop_front();
        if (estimate !== exp_res.est) report_mismatch("estimate", estimate, exp_res.est);
        if (gain !== exp_res.gain) report_mismatch("gain", gain, exp_res.gain);
      end
    end
  end

  // output side: random stalls, plus two long hold-offs so the input backs up
  initial begin
    int hold_left, ready_left, next_long_hold;
    hold_left = 0;
    ready_left = 0;
    next_long_hold = 40;
    wait (!rst);
    forever begin
      @(negedge clk);
      if (results_seen >= next_long_hold) begin
        hold_left = LONG_HOLD;
        next_long_hold = (next_long_hold < 300) ? 300 : 1 << 30;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
        if (ready_left > 0) begin
          ready_left--;
        end else begin
          ready_left = ($urandom_range(0, 7) == 0) ? $urandom_range(50, 150)
                                                   : $urandom_range(1, 12);
          hold_left = pick_gap();
        end
      end
    end
  end

  initial begin
    row_t row;
    logic signed [skf_pkg::SAMPLE_WIDTH-1:0] smp, last_smp;
    logic rs;
    logic [skf_pkg::REG_WIDTH-1:0] qv, rv;
    bit bursty;
    int pause_at;
    last_smp = '0;
    repeat (10) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);

    foreach (directed_rows[n]) begin
      row = directed_rows[n];
      case (row.kind)
        ROW_SET_Q: begin
          quiesce();
          write_noise_reg(skf_pkg::REG_PROCESS_NOISE, row.val);
        end
        ROW_SET_R: begin
          quiesce();
          write_noise_reg(skf_pkg::REG_MEASUREMENT_NOISE, row.val);
        end
        default: begin
          offer_sample(row.val[skf_pkg::SAMPLE_WIDTH-1:0], row.rs, row.chk_est, row.est,
                       row.chk_gain, row.gain);
          idle_input(pick_gap());
        end
      endcase
    end

    for (int ph = 0; ph < N_PHASES; ph++) begin
      quiesce();
      case ($urandom_range(0, 3))
        0: qv = '0;
        1: qv = '1;
        2: qv = skf_pkg::REG_WIDTH'($urandom_range(0, 4095));
        default: qv = skf_pkg::REG_WIDTH'($urandom);
      endcase
      case ($urandom_range(0, 4))
        0: rv = '0;
        1: rv = skf_pkg::REG_WIDTH'(1);
        2: rv = '1;
        3: rv = skf_pkg::REG_WIDTH'($urandom_range(1, 4095));
        default: rv = skf_pkg::REG_WIDTH'($urandom);
      endcase
      write_noise_reg(skf_pkg::REG_PROCESS_NOISE, qv);
      write_noise_reg(skf_pkg::REG_MEASUREMENT_NOISE, rv);
      bursty = ($urandom_range(0, 3) == 0);
      pause_at = (ph == 2) ? PHASE_ITEMS / 2 : -1;
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i == pause_at) quiesce();
        case ($urandom_range(0, 9))
          0: smp = 16'sh7FFF;
          1: smp = 16'sh8000;
          2, 3, 4: smp = skf_pkg::SAMPLE_WIDTH'(int'(last_smp)
                                                + int'($urandom_range(0, 400)) - 200);
          default: smp = skf_pkg::SAMPLE_WIDTH'($urandom);
        endcase
        rs = ($urandom_range(0, 19) == 0);
        last_smp = smp;
        offer_sample(smp, rs, 1'b0, '0, 1'b0, '0);
        if (!bursty) idle_input(pick_gap());
      end
    end

    quiesce();
    if (mismatch_count == 0) begin
      $display("scalar_kalman_filter_core test passed");
    end else begin
      $display("scalar_kalman_filter_core test failed");
    end
    $finish;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("scalar_kalman_filter_core test failed");
    $finish;
  end

endmodule

// File: files.f
sv/skf_pkg.sv
sv/skf_front.sv
sv/skf_queue.sv
sv/skf_back.sv
sv/scalar_kalman_filter_core.sv
tb/tb_top.sv
